[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the vblank reference clock.
// Depends on nothing; the synthesis build defines SYNTH to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset
`define VBRC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("vbrc assertion failed");
// Expression must never be true outside reset
`define VBRC_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("vbrc forbidden condition seen");
`else
`define VBRC_ASSERT(name, clk, rstn, prop)
`define VBRC_NEVER(name, clk, rstn, expr)
`endif
`endif

[rtl/core/vbrc_pkg.sv]
// Types, constants and sequencer states of the vblank reference clock.
// Used by vbrc_div and vblank_reference_clock.
package vbrc_pkg;

  localparam int unsigned VBRC_MAX_CATCHUP   = 64;
  localparam int unsigned VBRC_FRACTION_BITS = 32;

  // Divider: Q40.32 interval quotient is the widest dividend
  localparam int unsigned VBRC_DIV_W = 72;
  localparam int unsigned VBRC_DVS_W = 8;

  // Overdue threshold is 1.3 periods; a period divides by ten as
  // (p * DLY_RECIP) >> 35, exact for every 32-bit p
  localparam logic [31:0] DLY_RECIP = 32'hCCCC_CCCD;

  localparam logic [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;

  // Reset values of the configuration registers
  localparam logic [31:0] SYS_FREQ_RST   = 32'd1000000000;
  localparam logic [7:0]  REFRESH_RST    = 8'd60;
  localparam logic [31:0] CLOCK_SPEED_RST = 32'h0100_0000;

  typedef enum logic [2:0] {
    CFG_SYS_FREQ    = 3'd0,
    CFG_REFRESH     = 3'd1,
    CFG_CLOCK_SPEED = 3'd2,
    CFG_USE_VBLANK  = 3'd3,
    CFG_OFFSET      = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_IV_GO,
    ST_IV_WAIT,
    ST_ADV_MUL,
    ST_ADV_ADD,
    ST_PER_GO,
    ST_PER_WAIT,
    ST_DLY,
    ST_CATCH,
    ST_DIFF,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_SAT,
    ST_CAND,
    ST_MONO,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic                  start;
    logic [VBRC_DIV_W-1:0] dividend;
    logic [VBRC_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VBRC_DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/vbrc_div.sv]
// Restoring divider, one quotient bit per cycle, for the reference clock.
// Depends on vbrc_pkg for the dividend and divisor widths.
module vbrc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vbrc_pkg::div_req_t req_i,
  output vbrc_pkg::div_rsp_t rsp_o
);
  import vbrc_pkg::*;

  localparam int unsigned CW = $clog2(VBRC_DIV_W + 1);

  logic [VBRC_DIV_W-1:0] quo_q;
  logic [VBRC_DVS_W-1:0] rem_q, dvs_q, rem_nx;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q, done_q, fits;
  logic [VBRC_DVS_W:0]   trial, diff;

  // Trial subtract of the next partial remainder
  always_comb begin
    trial  = {rem_q, quo_q[VBRC_DIV_W-1]};
    diff   = trial - {1'b0, dvs_q};
    fits   = (trial >= {1'b0, dvs_q});
    rem_nx = fits ? diff[VBRC_DVS_W-1:0] : trial[VBRC_DVS_W-1:0];
  end

  // Shift in one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      quo_q  <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
      cnt_q  <= CW'(VBRC_DIV_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      quo_q <= {quo_q[VBRC_DIV_W-2:0], fits};
      rem_q <= rem_nx;
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/core/vblank_reference_clock.sv]
// Top level of the vblank reference clock: sequencer, state and shared units.
// Depends on vbrc_pkg, vbrc_div and assert_macros.svh.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   in       | in_valid_i / in_ready_o    | func, vblank_count, host_time, interp.
//   out      | out_valid_o / out_ready_i  | time_value, overflow flag, missed
//   cfg      | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// One request at a time. A vblank event with an advance runs the 72-step
// divider for the interval. A vblank-mode query makes two passes through
// the shared divider, then takes one catch-up step per overdue vblank (at
// most MAX_CATCHUP). Reset clears all clock state; no clearing pass. A
// result stalled at the output stage holds the sequencer only once the next
// result is ready.
module vblank_reference_clock #(
  parameter int unsigned MAX_CATCHUP   = vbrc_pkg::VBRC_MAX_CATCHUP,
  parameter int unsigned FRACTION_BITS = vbrc_pkg::VBRC_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  vblank_count_i,
  input  logic [62:0] host_time_i,
  input  logic        interpolate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [63:0] time_value_o,
  output logic        catch_up_overflow_o,
  output logic [31:0] total_missed_o
);
  import vbrc_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned SW = $clog2(MAX_CATCHUP + 1);
  localparam int unsigned FB = FRACTION_BITS;

  // Configuration registers
  logic [31:0] sys_freq_q, clk_speed_q;
  logic [7:0]  refresh_q;
  logic        use_vb_q;
  logic [63:0] offset_q;

  // Clock state
  logic [63:0] ct_q, lit_q, lvt_q;
  logic [FB-1:0] tf_q;
  logic [31:0] pend_q, miss_q;

  // Request and working registers
  st_e         st_q, st_d;
  logic        func_q, interp_q, flag_q, neg_q;
  logic [7:0]  cnt_q;
  logic [62:0] now_q;
  logic [63:0] prod_q, mhi_q, mlo_q, mag_q, m_q, cand_q;
  logic [71:0] ival_q;
  logic [31:0] per_q;
  logic [35:0] dly_q;
  logic [79:0] adv_q;
  logic [SW-1:0] step_q;

  // Output stage
  logic        ov_q, oflag_q;
  logic [63:0] otime_q;
  logic [31:0] omiss_q;

  // Combinational signals
  logic        acc, adv_ok, due, at_max, ld;
  logic [7:0]  rdiv;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, tgt, d_c, sat_r, cap, elapsed, res_c, whole_in;
  logic [FB-1:0] fr_in;
  logic [FB:0]   fsum;
  logic [28:0]   dq;
  logic [3:0]    p10, rem10;
  logic [1:0]    r3;
  logic [35:0]   dly_c;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  vbrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared datapath terms
  always_comb begin
    acc    = in_valid_i && in_ready_o;
    adv_ok = ({24'h0, vblank_count_i} >= pend_q) && (vblank_count_i != 8'h0);
    rdiv   = (refresh_q == 8'h0) ? 8'h1 : refresh_q;
    tgt    = lvt_q + {28'h0, dly_q};
    due    = $signed({1'b0, now_q}) >= $signed(tgt);
    at_max = (step_q == SW'(MAX_CATCHUP));
    d_c    = {1'b0, now_q} - lvt_q;
    sat_r  = {mhi_q[55:0], 8'h00} + {24'h0, mlo_q[63:24]};
    cap    = {23'h0, ival_q[71:31]};
    if (neg_q) begin
      elapsed = 64'h0 - m_q;
    end else begin
      elapsed = (m_q > cap) ? cap : m_q;
    end
    // Advance by n intervals or by one
    if (st_q == ST_ADV_ADD) begin
      fr_in    = adv_q[31 -: FB];
      whole_in = {16'h0, adv_q[79:32]};
    end else begin
      fr_in    = ival_q[31 -: FB];
      whole_in = {24'h0, ival_q[71:32]};
    end
    fsum = {1'b0, tf_q} + {1'b0, fr_in};
    // Shared 32x32 multiplier
    mul_a = clk_speed_q;
    mul_b = sys_freq_q;
    case (st_q)
      ST_DLY: begin
        mul_a = per_q;
        mul_b = DLY_RECIP;
      end
      ST_MUL_HI: mul_b = mag_q[63:32];
      ST_MUL_LO: mul_b = mag_q[31:0];
      default:   mul_b = sys_freq_q;
    endcase
    mul_p = {32'h0, mul_a} * {32'h0, mul_b};
    // Overdue delay: p + 3*(p/10) + (3*(p%10))/10 equals 13*p/10
    dq    = mul_p[63:35];
    p10   = {dq[0], 3'b000} + {dq[2:0], 1'b0};
    rem10 = per_q[3:0] - p10;
    r3    = (rem10 >= 4'd7) ? 2'd2 : ((rem10 >= 4'd4) ? 2'd1 : 2'd0);
    dly_c = {4'h0, per_q} + {6'h0, dq, 1'b0} + {7'h0, dq} + {34'h0, r3};
    if (!use_vb_q) begin
      res_c = {1'b0, now_q} + offset_q;
    end else begin
      res_c = interp_q ? lit_q : ct_q;
    end
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (acc) begin
          if (func_i) begin
            st_d = use_vb_q ? ST_MUL : ST_DONE;
          end else begin
            st_d = adv_ok ? ST_MUL : ST_IDLE;
          end
        end
      end
      ST_MUL:      st_d = ST_IV_GO;
      ST_IV_GO:    st_d = ST_IV_WAIT;
      ST_IV_WAIT:  if (div_rsp.done) st_d = func_q ? ST_PER_GO : ST_ADV_MUL;
      ST_ADV_MUL:  st_d = ST_ADV_ADD;
      ST_ADV_ADD:  st_d = ST_IDLE;
      ST_PER_GO:   st_d = ST_PER_WAIT;
      ST_PER_WAIT: if (div_rsp.done) st_d = ST_DLY;
      ST_DLY:      st_d = ST_CATCH;
      ST_CATCH: begin
        if (!due || at_max) st_d = interp_q ? ST_DIFF : ST_DONE;
      end
      ST_DIFF:     st_d = ST_MUL_HI;
      ST_MUL_HI:   st_d = ST_MUL_LO;
      ST_MUL_LO:   st_d = ST_SAT;
      ST_SAT:      st_d = ST_CAND;
      ST_CAND:     st_d = ST_MONO;
      ST_MONO:     st_d = ST_DONE;
      ST_DONE:     if (ld) st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o       = (st_q == ST_IDLE);
    ld               = (st_q == ST_DONE) && (!ov_q || out_ready_i);
    div_req.start    = 1'b0;
    div_req.dividend = {prod_q, 8'h00};
    div_req.divisor  = rdiv;
    unique case (st_q)
      ST_IV_GO: div_req.start = 1'b1;
      ST_PER_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {40'h0, sys_freq_q};
      end
      default: div_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_freq_q  <= SYS_FREQ_RST;
      refresh_q   <= REFRESH_RST;
      clk_speed_q <= CLOCK_SPEED_RST;
      use_vb_q    <= 1'b0;
      offset_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYS_FREQ:    sys_freq_q  <= cfg_wdata_i[31:0];
        CFG_REFRESH:     refresh_q   <= cfg_wdata_i[7:0];
        CFG_CLOCK_SPEED: clk_speed_q <= cfg_wdata_i[31:0];
        CFG_USE_VBLANK:  use_vb_q    <= cfg_wdata_i[0];
        CFG_OFFSET:      offset_q    <= cfg_wdata_i;
        default:         use_vb_q    <= use_vb_q;
      endcase
    end
  end

  // Clock state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_q     <= '0;
      lit_q    <= '0;
      lvt_q    <= '0;
      tf_q     <= '0;
      pend_q   <= '0;
      miss_q   <= '0;
      func_q   <= 1'b0;
      interp_q <= 1'b0;
      flag_q   <= 1'b0;
      neg_q    <= 1'b0;
      cnt_q    <= '0;
      now_q    <= '0;
      prod_q   <= '0;
      mhi_q    <= '0;
      mlo_q    <= '0;
      mag_q    <= '0;
      m_q      <= '0;
      cand_q   <= '0;
      ival_q   <= '0;
      per_q    <= '0;
      dly_q    <= '0;
      adv_q    <= '0;
      step_q   <= '0;
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (acc) begin
            func_q   <= func_i;
            interp_q <= interpolate_i;
            cnt_q    <= vblank_count_i;
            now_q    <= host_time_i;
            flag_q   <= 1'b0;
            step_q   <= '0;
            if (!func_i) begin
              lvt_q  <= {1'b0, host_time_i};
              pend_q <= '0;
            end
          end
        end
        ST_MUL:      prod_q <= mul_p;
        ST_IV_WAIT:  if (div_rsp.done) ival_q <= div_rsp.quotient;
        ST_ADV_MUL:  adv_q <= ival_q * {72'h0, cnt_q};
        ST_PER_WAIT: if (div_rsp.done) per_q <= div_rsp.quotient[31:0];
        ST_DLY:      dly_q <= dly_c;
        ST_CATCH: begin
          // Count one overdue vblank and advance a single interval; at MAX_CATCHUP flag overflow instead
          if (due && at_max) begin
            flag_q <= 1'b1;
          end else if (due) begin
            pend_q <= pend_q + 32'h1;
            miss_q <= miss_q + 32'h1;
            lvt_q  <= lvt_q + {32'h0, per_q};
            ct_q   <= ct_q + whole_in + {63'h0, fsum[FB]};
            tf_q   <= fsum[FB-1:0];
            step_q <= step_q + SW'(1);
          end
        end
        ST_ADV_ADD: begin
          ct_q <= ct_q + whole_in + {63'h0, fsum[FB]};
          tf_q <= fsum[FB-1:0];
        end
        ST_DIFF: begin
          neg_q <= d_c[63];
          mag_q <= d_c[63] ? (64'h0 - d_c) : d_c;
        end
        ST_MUL_HI: mhi_q <= mul_p;
        ST_MUL_LO: mlo_q <= mul_p;
        ST_SAT: begin
          if (|mhi_q[63:55] || sat_r[63]) begin
            m_q <= SAT63;
          end else begin
            m_q <= sat_r;
          end
        end
        ST_CAND: cand_q <= ct_q + elapsed;
        ST_MONO: begin
          // Never move the interpolated time backwards
          if (cand_q != lit_q && $signed(cand_q) > $signed(lit_q)) lit_q <= cand_q;
        end
        default: ct_q <= ct_q;
      endcase
    end
  end

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      otime_q <= '0;
      oflag_q <= 1'b0;
      omiss_q <= '0;
    end else begin
      if (ld) begin
        ov_q    <= 1'b1;
        otime_q <= res_c;
        oflag_q <= flag_q && use_vb_q;
        omiss_q <= miss_q;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = ov_q;
  assign time_value_o        = otime_q;
  assign catch_up_overflow_o = oflag_q;
  assign total_missed_o      = omiss_q;

  // Checks on the sequencer
  `VBRC_ASSERT(a_div_done_waited, clk_i, rst_ni,
    div_rsp.done |-> (st_q == ST_IV_WAIT || st_q == ST_PER_WAIT))
  `VBRC_NEVER(a_step_bound, clk_i, rst_ni, step_q > SW'(MAX_CATCHUP))
  `VBRC_ASSERT(a_event_no_result, clk_i, rst_ni,
    (acc && !func_i) |=> (st_q == ST_MUL || st_q == ST_IDLE))
  `VBRC_ASSERT(a_catch_moves_clock, clk_i, rst_ni,
    (st_q == ST_CATCH && due && !at_max) |=> (miss_q == $past(miss_q) + 32'h1))

endmodule
